@@ rtl/tsfs_pkg.sv @@
package tsfs_pkg;

    localparam int SAMPLES_PER_AXIS  = 5;
    localparam int ADC_BITS          = 12;
    localparam int RELEASE_MIN_SCANS = 2;

    localparam int SAMPLE_W   = 12;
    localparam int COORD_W    = 16;
    localparam int GAIN_W     = 21;
    localparam int OFFSET_W   = 16;
    localparam int THRESH_W   = 12;
    localparam int EXTENT_W   = 16;
    localparam int PRESS_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    localparam int GROUPS = 4;
    localparam int GRP_W  = 2;
    localparam int POS_W  = $clog2(SAMPLES_PER_AXIS);
    localparam int SUM_W  = ADC_BITS + POS_W;

    // trimmed mean: multiply by a rounded-up reciprocal, exact for SUM_W-bit numerators
    localparam int TRIM_DIV  = SAMPLES_PER_AXIS - 2;
    localparam int DIV_SHIFT = SUM_W + $clog2(TRIM_DIV);
    localparam int MULT_W    = DIV_SHIFT + 1;
    localparam int PROD_W    = SUM_W + MULT_W;
    localparam longint unsigned DIV_MULT_L =
        ((longint'(1) << DIV_SHIFT) + longint'(TRIM_DIV) - 1) / longint'(TRIM_DIV);
    localparam logic [MULT_W-1:0] DIV_MULT = MULT_W'(DIV_MULT_L);

    localparam int CMP_W = (ADC_BITS > THRESH_W) ? ADC_BITS : THRESH_W;
    localparam int CAL_W = (GAIN_W + ADC_BITS + 1 > 32) ? GAIN_W + ADC_BITS + 1 : 32;
    localparam int CAL_FRAC = 16;

    localparam logic [PRESS_W-1:0] PRESS_MAX   = '1;
    localparam logic [PRESS_W-1:0] RELEASE_MIN = PRESS_W'(RELEASE_MIN_SCANS);
    localparam logic [COORD_W-1:0] NO_POINT    = '1;
    localparam logic [GRP_W-1:0]   LAST_GROUP  = GRP_W'(GROUPS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_RAW_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_GAIN        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_GAIN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_AGREE_WINDOW  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_EXTENT = 3'd7;

    typedef struct packed {
        logic             rel;
        logic [GRP_W-1:0] grp;
        logic [SUM_W-1:0] num;
    } t_event;

    typedef struct packed {
        logic                raw_mode;
        logic [GAIN_W-1:0]   x_gain;
        logic [OFFSET_W-1:0] x_offset;
        logic [GAIN_W-1:0]   y_gain;
        logic [OFFSET_W-1:0] y_offset;
        logic [THRESH_W-1:0] min_valid;
        logic [THRESH_W-1:0] agree_window;
        logic [EXTENT_W-1:0] screen_extent;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] down_x;
        logic [COORD_W-1:0] down_y;
        logic [COORD_W-1:0] up_x;
        logic [COORD_W-1:0] up_y;
        logic               reading_ok;
    } t_result;

    function automatic logic agree(logic [ADC_BITS-1:0] a, logic [ADC_BITS-1:0] b,
                                   logic [THRESH_W-1:0] w);
        logic [ADC_BITS-1:0] d;
        d = (a > b) ? a - b : b - a;
        return CMP_W'(d) < CMP_W'(w);
    endfunction

endpackage

@@ rtl/tsfs_front.sv @@
module tsfs_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_beat,
    input  logic                           i_pen_down,
    input  logic [tsfs_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                           o_push,
    output tsfs_pkg::t_event               o_event
);

    logic [tsfs_pkg::POS_W-1:0]    r_pos;
    logic [tsfs_pkg::GRP_W-1:0]    r_grp;
    logic [tsfs_pkg::SUM_W-1:0]    r_sum;
    logic [tsfs_pkg::ADC_BITS-1:0] r_min;
    logic [tsfs_pkg::ADC_BITS-1:0] r_max;

    logic [tsfs_pkg::ADC_BITS-1:0] s;
    logic [tsfs_pkg::SUM_W-1:0]    sum_acc;
    logic [tsfs_pkg::ADC_BITS-1:0] min_acc;
    logic [tsfs_pkg::ADC_BITS-1:0] max_acc;
    logic                          last;

    always_comb begin
        s       = tsfs_pkg::ADC_BITS'(i_sample);
        sum_acc = r_sum + tsfs_pkg::SUM_W'(s);
        min_acc = (s < r_min) ? s : r_min;
        max_acc = (s > r_max) ? s : r_max;
        last    = (r_pos == tsfs_pkg::POS_W'(tsfs_pkg::SAMPLES_PER_AXIS - 1));
        o_push  = i_beat && (!i_pen_down || last);
        o_event.rel = !i_pen_down;
        o_event.grp = r_grp;
        o_event.num = sum_acc - tsfs_pkg::SUM_W'(min_acc) - tsfs_pkg::SUM_W'(max_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_grp <= '0;
            r_sum <= '0;
            r_min <= '1;
            r_max <= '0;
        end else if (i_beat) begin
            if (!i_pen_down || last) begin
                r_pos <= '0;
                r_sum <= '0;
                r_min <= '1;
                r_max <= '0;
                r_grp <= i_pen_down ? r_grp + 1'b1 : '0;
            end else begin
                r_pos <= r_pos + 1'b1;
                r_sum <= sum_acc;
                r_min <= min_acc;
                r_max <= max_acc;
            end
        end
    end

endmodule

@@ rtl/tsfs_fifo.sv @@
module tsfs_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tsfs_pkg::t_event i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output tsfs_pkg::t_event o_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    tsfs_pkg::t_event  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [PTR_W:0]    r_count;
    logic              do_pop;

    assign o_full  = (r_count == (PTR_W + 1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/tsfs_back.sv @@
module tsfs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tsfs_pkg::t_cfg    i_cfg,
    input  logic              i_ev_valid,
    input  tsfs_pkg::t_event  i_event,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output tsfs_pkg::t_result o_result
);

    logic adv;

    // divide stage
    logic                          r_a_valid;
    logic                          r_a_rel;
    logic [tsfs_pkg::GRP_W-1:0]    r_a_grp;
    logic [tsfs_pkg::PROD_W-1:0]   r_a_prod;

    // pass / scan stage
    logic [tsfs_pkg::ADC_BITS-1:0] r_pass [tsfs_pkg::GROUPS-1];
    logic                          r_fail;
    logic [tsfs_pkg::PRESS_W-1:0]  r_press;

    logic                          r_b_valid;
    logic                          r_b_rel;
    logic                          r_b_ok;
    logic                          r_b_long;
    logic [tsfs_pkg::ADC_BITS-1:0] r_b_mx;
    logic [tsfs_pkg::ADC_BITS-1:0] r_b_my;

    // calibration multiply stage
    logic                          r_c_valid;
    logic                          r_c_rel;
    logic                          r_c_ok;
    logic                          r_c_long;
    logic [tsfs_pkg::ADC_BITS-1:0] r_c_mx;
    logic [tsfs_pkg::ADC_BITS-1:0] r_c_my;
    logic [tsfs_pkg::CAL_W-1:0]    r_c_px;
    logic [tsfs_pkg::CAL_W-1:0]    r_c_py;

    // coordinate store and output
    logic [tsfs_pkg::COORD_W-1:0]  r_coord_x;
    logic [tsfs_pkg::COORD_W-1:0]  r_coord_y;
    logic                          r_out_valid;
    tsfs_pkg::t_result             r_out;

    logic [tsfs_pkg::ADC_BITS-1:0] trimmed;
    logic                          fail_now;
    logic                          scan_end;
    logic                          scan_ok;
    logic [tsfs_pkg::ADC_BITS:0]   sum_x;
    logic [tsfs_pkg::ADC_BITS:0]   sum_y;
    logic [tsfs_pkg::COORD_W-1:0]  new_x;
    logic [tsfs_pkg::COORD_W-1:0]  new_y;
    logic [tsfs_pkg::COORD_W-1:0]  cur_x;
    logic [tsfs_pkg::COORD_W-1:0]  cur_y;
    logic                          upd;
    tsfs_pkg::t_result             n_out;

    assign adv      = !r_out_valid || i_ready;
    assign o_pop    = adv && i_ev_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        trimmed  = tsfs_pkg::ADC_BITS'(r_a_prod >> tsfs_pkg::DIV_SHIFT);
        fail_now = tsfs_pkg::CMP_W'(trimmed) < tsfs_pkg::CMP_W'(i_cfg.min_valid);
        scan_end = !r_a_rel && (r_a_grp == tsfs_pkg::LAST_GROUP);
        scan_ok  = !(r_fail || fail_now)
                   && tsfs_pkg::agree(r_pass[0], r_pass[2], i_cfg.agree_window)
                   && tsfs_pkg::agree(r_pass[1], trimmed, i_cfg.agree_window);
        sum_x    = {1'b0, r_pass[0]} + {1'b0, r_pass[2]};
        sum_y    = {1'b0, r_pass[1]} + {1'b0, trimmed};
    end

    always_comb begin
        if (i_cfg.raw_mode) begin
            new_x = tsfs_pkg::COORD_W'(r_c_mx);
            new_y = tsfs_pkg::COORD_W'(r_c_my);
        end else begin
            new_x = r_c_px[tsfs_pkg::CAL_FRAC +: tsfs_pkg::COORD_W] + i_cfg.x_offset;
            new_y = r_c_py[tsfs_pkg::CAL_FRAC +: tsfs_pkg::COORD_W] + i_cfg.y_offset;
        end
        upd   = r_c_valid && !r_c_rel && r_c_ok;
        cur_x = upd ? new_x : r_coord_x;
        cur_y = upd ? new_y : r_coord_y;
        if (r_c_rel) begin
            n_out.down_x     = tsfs_pkg::NO_POINT;
            n_out.down_y     = tsfs_pkg::NO_POINT;
            n_out.up_x       = r_c_long ? i_cfg.screen_extent - r_coord_y : tsfs_pkg::NO_POINT;
            n_out.up_y       = r_c_long ? r_coord_x : tsfs_pkg::NO_POINT;
            n_out.reading_ok = 1'b0;
        end else begin
            n_out.down_x     = i_cfg.screen_extent - cur_y;
            n_out.down_y     = cur_x;
            n_out.up_x       = tsfs_pkg::NO_POINT;
            n_out.up_y       = tsfs_pkg::NO_POINT;
            n_out.reading_ok = r_c_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_rel  <= i_event.rel;
            r_a_grp  <= i_event.grp;
            r_a_prod <= tsfs_pkg::PROD_W'(i_event.num) * tsfs_pkg::PROD_W'(tsfs_pkg::DIV_MULT);

            r_b_rel  <= r_a_rel;
            r_b_ok   <= scan_ok;
            r_b_long <= r_press > tsfs_pkg::RELEASE_MIN;
            r_b_mx   <= sum_x[tsfs_pkg::ADC_BITS:1];
            r_b_my   <= sum_y[tsfs_pkg::ADC_BITS:1];

            r_c_rel  <= r_b_rel;
            r_c_ok   <= r_b_ok;
            r_c_long <= r_b_long;
            r_c_mx   <= r_b_mx;
            r_c_my   <= r_b_my;
            r_c_px   <= $signed({{(tsfs_pkg::CAL_W - tsfs_pkg::GAIN_W){i_cfg.x_gain[tsfs_pkg::GAIN_W-1]}},
                                 i_cfg.x_gain})
                      * $signed({{(tsfs_pkg::CAL_W - tsfs_pkg::ADC_BITS){1'b0}}, r_b_mx});
            r_c_py   <= $signed({{(tsfs_pkg::CAL_W - tsfs_pkg::GAIN_W){i_cfg.y_gain[tsfs_pkg::GAIN_W-1]}},
                                 i_cfg.y_gain})
                      * $signed({{(tsfs_pkg::CAL_W - tsfs_pkg::ADC_BITS){1'b0}}, r_b_my});

            r_out    <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_fail      <= 1'b0;
            r_press     <= '0;
            r_coord_x   <= '0;
            r_coord_y   <= '0;
            for (int i = 0; i < tsfs_pkg::GROUPS - 1; i++) begin
                r_pass[i] <= '0;
            end
        end else if (adv) begin
            r_a_valid   <= o_pop;
            r_b_valid   <= r_a_valid && (r_a_rel || scan_end);
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid;
            if (r_a_valid) begin
                if (r_a_rel) begin
                    r_fail  <= 1'b0;
                    r_press <= '0;
                end else if (scan_end) begin
                    r_fail  <= 1'b0;
                    if (r_press != tsfs_pkg::PRESS_MAX) begin
                        r_press <= r_press + 1'b1;
                    end
                end else begin
                    r_fail <= r_fail || fail_now;
                    r_pass[r_a_grp] <= trimmed;
                end
            end
            if (upd) begin
                r_coord_x <= new_x;
                r_coord_y <= new_y;
            end
        end
    end

endmodule

@@ rtl/touch_sample_filter_scan_core.sv @@
// Channel   Direction  Handshake            Payload
// sample    in         i_valid / o_ready    i_pen_down, i_sample
// point     out        o_valid / i_ready    o_down_x, o_down_y, o_up_x, o_up_y, o_reading_ok
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One sample beat per cycle while o_ready is high. A result passes a queue slot, the reciprocal
// multiply, the pass/scan stage, the calibration multiply and the output register in turn.
// A 4-entry event queue sits between the sample front end and the back pipeline; o_ready
// drops only while it is full, and the back pipeline holds while the output register waits.
// Synchronous active-low reset; config returns to its defaults.
module touch_sample_filter_scan_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_pen_down,
    input  logic [tsfs_pkg::SAMPLE_W-1:0]    i_sample,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [tsfs_pkg::COORD_W-1:0]     o_down_x,
    output logic [tsfs_pkg::COORD_W-1:0]     o_down_y,
    output logic [tsfs_pkg::COORD_W-1:0]     o_up_x,
    output logic [tsfs_pkg::COORD_W-1:0]     o_up_y,
    output logic                             o_reading_ok,
    input  logic                             i_cfg_we,
    input  logic [tsfs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tsfs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    tsfs_pkg::t_cfg    r_cfg;
    tsfs_pkg::t_event  push_ev;
    tsfs_pkg::t_event  pop_ev;
    tsfs_pkg::t_result result;
    logic              push;
    logic              q_full;
    logic              q_valid;
    logic              pop;
    logic              beat;

    assign o_ready = !q_full;
    assign beat    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.raw_mode      <= 1'b0;
            r_cfg.x_gain        <= tsfs_pkg::GAIN_W'(5120);
            r_cfg.x_offset      <= '0;
            r_cfg.y_gain        <= tsfs_pkg::GAIN_W'(5120);
            r_cfg.y_offset      <= '0;
            r_cfg.min_valid     <= tsfs_pkg::THRESH_W'(50);
            r_cfg.agree_window  <= tsfs_pkg::THRESH_W'(50);
            r_cfg.screen_extent <= tsfs_pkg::EXTENT_W'(320);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tsfs_pkg::CFG_RAW_MODE:      r_cfg.raw_mode      <= i_cfg_data[0];
                tsfs_pkg::CFG_X_GAIN:        r_cfg.x_gain        <= i_cfg_data[tsfs_pkg::GAIN_W-1:0];
                tsfs_pkg::CFG_X_OFFSET:      r_cfg.x_offset      <= i_cfg_data[tsfs_pkg::OFFSET_W-1:0];
                tsfs_pkg::CFG_Y_GAIN:        r_cfg.y_gain        <= i_cfg_data[tsfs_pkg::GAIN_W-1:0];
                tsfs_pkg::CFG_Y_OFFSET:      r_cfg.y_offset      <= i_cfg_data[tsfs_pkg::OFFSET_W-1:0];
                tsfs_pkg::CFG_MIN_VALID:     r_cfg.min_valid     <= i_cfg_data[tsfs_pkg::THRESH_W-1:0];
                tsfs_pkg::CFG_AGREE_WINDOW:  r_cfg.agree_window  <= i_cfg_data[tsfs_pkg::THRESH_W-1:0];
                tsfs_pkg::CFG_SCREEN_EXTENT: r_cfg.screen_extent <= i_cfg_data[tsfs_pkg::EXTENT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tsfs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_beat     (beat),
        .i_pen_down (i_pen_down),
        .i_sample   (i_sample),
        .o_push     (push),
        .o_event    (push_ev)
    );

    tsfs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_ev),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_data  (pop_ev)
    );

    tsfs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_ev_valid (q_valid),
        .i_event    (pop_ev),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (result)
    );

    assign o_down_x     = result.down_x;
    assign o_down_y     = result.down_y;
    assign o_up_x       = result.up_x;
    assign o_up_y       = result.up_y;
    assign o_reading_ok = result.reading_ok;

endmodule
